// ===== src/pre_pkg.sv =====
// Shared types, codes and the microcode table for the reprojection-error block.
// Used by pre_alu.sv and point_reprojection_error.sv; depends on nothing.
package pre_pkg;

  // Input word opcodes
  localparam logic IN_LOAD  = 1'b0;
  localparam logic IN_POINT = 1'b1;

  localparam int unsigned STORE_WORDS = 24;
  localparam int unsigned MEM_DEPTH   = 48;
  localparam int unsigned ADDR_W      = 6;
  localparam int unsigned SUM_W       = 48;
  localparam int unsigned CNT_W       = 16;

  typedef struct packed {
    logic              opcode;
    logic [4:0]        coef_index;
    logic signed [31:0] coef_value;
    logic signed [31:0] model_x;
    logic signed [31:0] model_y;
    logic signed [31:0] image_x;
    logic signed [31:0] image_y;
    logic              last_point;
  } pre_in_t;

  typedef struct packed {
    logic signed [31:0] proj_u;
    logic signed [31:0] proj_v;
    logic [31:0]        point_error;
    logic [31:0]        mean_error;
    logic               status;
    logic               is_last;
  } pre_out_t;

  // Arithmetic unit operations
  localparam logic [2:0] OP_ADD  = 3'd0;
  localparam logic [2:0] OP_MUL  = 3'd1;
  localparam logic [2:0] OP_DIV  = 3'd2;
  localparam logic [2:0] OP_DIVR = 3'd3;  // zero divisor gives 0, no fault
  localparam logic [2:0] OP_ERR  = 3'd4;  // distance to observed point
  localparam logic [2:0] OP_MEAN = 3'd5;

  typedef struct packed {
    logic               start;
    logic [2:0]         op;
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic signed [31:0] img_x;
    logic signed [31:0] img_y;
    logic [SUM_W-1:0]   sum;
    logic [CNT_W-1:0]   cnt;
  } pre_req_t;

  typedef struct packed {
    logic        done;
    logic        fault;
    logic [31:0] res;
  } pre_rsp_t;

  // Operand file: 0..23 coefficients, 24..47 scratch, above that constants/inputs
  localparam logic [5:0] A_T0   = 6'd24;
  localparam logic [5:0] A_T1   = 6'd25;
  localparam logic [5:0] A_P0   = 6'd26;
  localparam logic [5:0] A_P1   = 6'd27;
  localparam logic [5:0] A_P2   = 6'd28;
  localparam logic [5:0] A_XN   = 6'd29;
  localparam logic [5:0] A_YN   = 6'd30;
  localparam logic [5:0] A_ZN   = 6'd31;
  localparam logic [5:0] A_XX   = 6'd32;
  localparam logic [5:0] A_R2   = 6'd33;
  localparam logic [5:0] A_R3   = 6'd34;
  localparam logic [5:0] A_R22  = 6'd35;
  localparam logic [5:0] A_R33  = 6'd36;
  localparam logic [5:0] A_KU   = 6'd37;
  localparam logic [5:0] A_KD   = 6'd38;
  localparam logic [5:0] A_DR   = 6'd39;
  localparam logic [5:0] A_DT   = 6'd40;
  localparam logic [5:0] A_Q0   = 6'd41;
  localparam logic [5:0] A_Q1   = 6'd42;
  localparam logic [5:0] A_Q2   = 6'd43;
  localparam logic [5:0] A_U    = 6'd44;
  localparam logic [5:0] A_V    = 6'd45;
  localparam logic [5:0] A_PE   = 6'd46;
  localparam logic [5:0] A_ONE  = 6'd48;
  localparam logic [5:0] A_ZERO = 6'd49;
  localparam logic [5:0] A_MX   = 6'd50;
  localparam logic [5:0] A_MY   = 6'd51;

  // Mode masks: bit m set means the step runs in distortion mode m
  localparam logic [3:0] M_ALL  = 4'b1111;
  localparam logic [3:0] M_DIS  = 4'b1110;
  localparam logic [3:0] M_RAT  = 4'b1000;
  localparam logic [3:0] M_POLY = 4'b0110;
  localparam logic [3:0] M_RAD  = 4'b0010;
  localparam logic [3:0] M_TAN  = 4'b1100;

  typedef struct packed {
    logic [2:0] op;
    logic [3:0] mask;
    logic [5:0] dst;
    logic [5:0] sa;
    logic [5:0] sb;
  } pre_uop_t;

  localparam int unsigned UC_LEN = 74;
  localparam int unsigned PC_W   = 7;

  localparam pre_uop_t UCODE [UC_LEN] = '{
    // pose rows
    '{OP_MUL,  M_ALL,  A_T0,  6'd0,   A_MX},
    '{OP_MUL,  M_ALL,  A_T1,  6'd1,   A_MY},
    '{OP_ADD,  M_ALL,  A_T0,  A_T0,   A_T1},
    '{OP_ADD,  M_ALL,  A_P0,  A_T0,   6'd2},
    '{OP_MUL,  M_ALL,  A_T0,  6'd3,   A_MX},
    '{OP_MUL,  M_ALL,  A_T1,  6'd4,   A_MY},
    '{OP_ADD,  M_ALL,  A_T0,  A_T0,   A_T1},
    '{OP_ADD,  M_ALL,  A_P1,  A_T0,   6'd5},
    '{OP_MUL,  M_ALL,  A_T0,  6'd6,   A_MX},
    '{OP_MUL,  M_ALL,  A_T1,  6'd7,   A_MY},
    '{OP_ADD,  M_ALL,  A_T0,  A_T0,   A_T1},
    '{OP_ADD,  M_ALL,  A_P2,  A_T0,   6'd8},
    // depth divide
    '{OP_DIV,  M_ALL,  A_XN,  A_P0,   A_P2},
    '{OP_DIV,  M_ALL,  A_YN,  A_P1,   A_P2},
    '{OP_DIV,  M_ALL,  A_ZN,  A_P2,   A_P2},
    // r2
    '{OP_MUL,  M_DIS,  A_XX,  A_XN,   A_XN},
    '{OP_MUL,  M_DIS,  A_T0,  A_YN,   A_YN},
    '{OP_ADD,  M_DIS,  A_T0,  A_XX,   A_T0},
    '{OP_ADD,  M_DIS,  A_R2,  A_T0,   A_ONE},
    // rational form
    '{OP_MUL,  M_RAT,  A_T0,  A_XX,   A_XN},
    '{OP_MUL,  M_RAT,  A_T1,  A_YN,   A_YN},
    '{OP_MUL,  M_RAT,  A_T1,  A_T1,   A_YN},
    '{OP_ADD,  M_RAT,  A_T0,  A_T0,   A_T1},
    '{OP_ADD,  M_RAT,  A_R3,  A_T0,   A_ONE},
    '{OP_MUL,  M_RAT,  A_R22, A_R2,   A_R2},
    '{OP_MUL,  M_RAT,  A_R33, A_R3,   A_R3},
    '{OP_MUL,  M_RAT,  A_T0,  6'd18,  A_R2},
    '{OP_ADD,  M_RAT,  A_T0,  A_ONE,  A_T0},
    '{OP_MUL,  M_RAT,  A_T1,  6'd19,  A_R22},
    '{OP_ADD,  M_RAT,  A_T0,  A_T0,   A_T1},
    '{OP_MUL,  M_RAT,  A_T1,  6'd20,  A_R33},
    '{OP_ADD,  M_RAT,  A_KU,  A_T0,   A_T1},
    '{OP_MUL,  M_RAT,  A_T0,  6'd21,  A_R2},
    '{OP_ADD,  M_RAT,  A_T0,  A_ONE,  A_T0},
    '{OP_MUL,  M_RAT,  A_T1,  6'd22,  A_R22},
    '{OP_ADD,  M_RAT,  A_T0,  A_T0,   A_T1},
    '{OP_MUL,  M_RAT,  A_T1,  6'd23,  A_R33},
    '{OP_ADD,  M_RAT,  A_KD,  A_T0,   A_T1},
    '{OP_DIVR, M_RAT,  A_DR,  A_KU,   A_KD},
    // two-term radial
    '{OP_MUL,  M_POLY, A_T0,  6'd18,  A_R2},
    '{OP_ADD,  M_POLY, A_T0,  A_ONE,  A_T0},
    '{OP_MUL,  M_POLY, A_T1,  A_R2,   A_R2},
    '{OP_MUL,  M_POLY, A_T1,  6'd19,  A_T1},
    '{OP_ADD,  M_POLY, A_DR,  A_T0,   A_T1},
    // tangential term
    '{OP_ADD,  M_RAD,  A_DT,  A_ZERO, A_ZERO},
    '{OP_ADD,  M_TAN,  A_T0,  6'd20,  6'd20},
    '{OP_MUL,  M_TAN,  A_T0,  A_T0,   A_XN},
    '{OP_MUL,  M_TAN,  A_T0,  A_T0,   A_YN},
    '{OP_ADD,  M_TAN,  A_T1,  A_XX,   A_XX},
    '{OP_ADD,  M_TAN,  A_T1,  A_R2,   A_T1},
    '{OP_MUL,  M_TAN,  A_T1,  6'd21,  A_T1},
    '{OP_ADD,  M_TAN,  A_DT,  A_T0,   A_T1},
    // apply distortion
    '{OP_MUL,  M_DIS,  A_T0,  A_XN,   A_DR},
    '{OP_MUL,  M_DIS,  A_T1,  A_YN,   A_DR},
    '{OP_ADD,  M_DIS,  A_XN,  A_T0,   A_DT},
    '{OP_ADD,  M_DIS,  A_YN,  A_T1,   A_DT},
    // intrinsics
    '{OP_MUL,  M_ALL,  A_T0,  6'd9,   A_XN},
    '{OP_MUL,  M_ALL,  A_T1,  6'd10,  A_YN},
    '{OP_ADD,  M_ALL,  A_T0,  A_T0,   A_T1},
    '{OP_MUL,  M_ALL,  A_T1,  6'd11,  A_ZN},
    '{OP_ADD,  M_ALL,  A_Q0,  A_T0,   A_T1},
    '{OP_MUL,  M_ALL,  A_T0,  6'd12,  A_XN},
    '{OP_MUL,  M_ALL,  A_T1,  6'd13,  A_YN},
    '{OP_ADD,  M_ALL,  A_T0,  A_T0,   A_T1},
    '{OP_MUL,  M_ALL,  A_T1,  6'd14,  A_ZN},
    '{OP_ADD,  M_ALL,  A_Q1,  A_T0,   A_T1},
    '{OP_MUL,  M_ALL,  A_T0,  6'd15,  A_XN},
    '{OP_MUL,  M_ALL,  A_T1,  6'd16,  A_YN},
    '{OP_ADD,  M_ALL,  A_T0,  A_T0,   A_T1},
    '{OP_MUL,  M_ALL,  A_T1,  6'd17,  A_ZN},
    '{OP_ADD,  M_ALL,  A_Q2,  A_T0,   A_T1},
    // final divide and distance
    '{OP_DIV,  M_ALL,  A_U,   A_Q0,   A_Q2},
    '{OP_DIV,  M_ALL,  A_V,   A_Q1,   A_Q2},
    '{OP_ERR,  M_ALL,  A_PE,  A_U,    A_V}
  };

endpackage

// ===== src/pre_alu.sv =====
// Shared arithmetic unit: saturating add, fixed-point multiply, bit-serial divide,
// distance (two squares plus bit-serial root). Depends on pre_pkg.
module pre_alu #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  pre_pkg::pre_req_t req,
  output pre_pkg::pre_rsp_t rsp
);

  localparam int DW = (32 + FRAC_BITS > 48) ? 32 + FRAC_BITS : 48;
  localparam int CW = $clog2(DW + 1);

  localparam logic [3:0] U_IDLE = 4'd0;
  localparam logic [3:0] U_MUL  = 4'd1;
  localparam logic [3:0] U_MFIN = 4'd2;
  localparam logic [3:0] U_DIV  = 4'd3;
  localparam logic [3:0] U_DFIN = 4'd4;
  localparam logic [3:0] U_E1   = 4'd5;
  localparam logic [3:0] U_E2   = 4'd6;
  localparam logic [3:0] U_E3   = 4'd7;
  localparam logic [3:0] U_SQRT = 4'd8;
  localparam logic [3:0] U_SFIN = 4'd9;

  localparam logic [31:0] S_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] S_MIN = 32'h8000_0000;

  logic [3:0]         st_r;
  logic [2:0]         op_r;
  logic signed [32:0] ma_r, mb_r;
  logic signed [65:0] p_r;
  logic [63:0]        sq_r;
  logic [31:0]        ay_r;
  logic [DW-1:0]      dvd_r, quo_r;
  logic [31:0]        dsr_r;
  logic [32:0]        rem_r;
  logic               neg_r;
  logic [CW-1:0]      cnt_r;
  logic [63:0]        rad_r;
  logic [35:0]        srem_r;
  logic [31:0]        root_r;
  logic               done_r, fault_r;
  logic               done_nxt;
  logic [31:0]        res_r;

  logic signed [32:0] add_s;
  logic [31:0]        add_res, abs_a, abs_b, ax, ay;
  logic signed [32:0] dx, dy;
  logic signed [65:0] mul_sh;
  logic [31:0]        mul_res, div_res;
  logic [32:0]        dstep;
  logic               dge, big_q;
  logic [35:0]        sstep, strial;
  logic               sge;
  logic [64:0]        e_sum;

  always_comb begin
    add_s   = {req.a[31], req.a} + {req.b[31], req.b};
    add_res = (add_s[32] != add_s[31]) ? (add_s[32] ? S_MIN : S_MAX) : add_s[31:0];
    abs_a   = req.a[31] ? -req.a : req.a;
    abs_b   = req.b[31] ? -req.b : req.b;
    dx      = {req.img_x[31], req.img_x} - {req.a[31], req.a};
    dy      = {req.img_y[31], req.img_y} - {req.b[31], req.b};
    ax      = dx[32] ? 32'(-dx) : dx[31:0];
    ay      = dy[32] ? 32'(-dy) : dy[31:0];

    // floor shift, then clamp to 32 bits
    mul_sh  = p_r >>> FRAC_BITS;
    if (&mul_sh[65:31] || ~|mul_sh[65:31]) mul_res = mul_sh[31:0];
    else mul_res = mul_sh[65] ? S_MIN : S_MAX;

    dstep   = {rem_r[31:0], dvd_r[DW-1]};
    dge     = dstep >= {1'b0, dsr_r};
    big_q   = |quo_r[DW-1:32];
    if (op_r == pre_pkg::OP_MEAN) div_res = big_q ? 32'hFFFF_FFFF : quo_r[31:0];
    else if (!neg_r) div_res = (big_q || quo_r[31]) ? S_MAX : quo_r[31:0];
    else if (big_q || (quo_r[31] && |quo_r[30:0])) div_res = S_MIN;
    else div_res = -quo_r[31:0];

    sstep   = {srem_r[33:0], rad_r[63:62]};
    strial  = {2'b00, root_r, 2'b01};
    sge     = sstep >= strial;
    e_sum   = {1'b0, sq_r} + {1'b0, p_r[63:0]};

    // answers decided in idle: add, divide by zero, unknown codes; the rest from their final state
    case (st_r)
      U_IDLE: begin
        if (!req.start) done_nxt = 1'b0;
        else if (req.op inside {pre_pkg::OP_MUL, pre_pkg::OP_MEAN, pre_pkg::OP_ERR})
          done_nxt = 1'b0;
        else if (req.op inside {pre_pkg::OP_DIV, pre_pkg::OP_DIVR})
          done_nxt = (req.b == '0);
        else done_nxt = 1'b1;
      end
      U_MFIN, U_DFIN, U_SFIN: done_nxt = 1'b1;
      U_E3:    done_nxt = e_sum[64];
      default: done_nxt = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= U_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= done_nxt;
      p_r    <= ma_r * mb_r;
      unique case (st_r)
        U_IDLE: begin
          if (req.start) begin
            op_r    <= req.op;
            fault_r <= 1'b0;
            unique case (req.op)
              pre_pkg::OP_ADD: begin
                res_r  <= add_res;
              end
              pre_pkg::OP_MUL: begin
                ma_r <= {req.a[31], req.a};
                mb_r <= {req.b[31], req.b};
                st_r <= U_MUL;
              end
              pre_pkg::OP_DIV, pre_pkg::OP_DIVR: begin
                if (req.b == '0) begin
                  if (req.op == pre_pkg::OP_DIV) begin
                    res_r   <= req.a[31] ? S_MIN : S_MAX;
                    fault_r <= 1'b1;
                  end else begin
                    res_r <= '0;
                  end
                end else begin
                  neg_r <= req.a[31] ^ req.b[31];
                  dvd_r <= DW'(abs_a) << FRAC_BITS;
                  dsr_r <= abs_b;
                  rem_r <= '0;
                  quo_r <= '0;
                  cnt_r <= CW'(DW);
                  st_r  <= U_DIV;
                end
              end
              pre_pkg::OP_MEAN: begin
                neg_r <= 1'b0;
                dvd_r <= DW'(req.sum);
                dsr_r <= 32'(req.cnt);
                rem_r <= '0;
                quo_r <= '0;
                cnt_r <= CW'(DW);
                st_r  <= U_DIV;
              end
              pre_pkg::OP_ERR: begin
                ma_r <= {1'b0, ax};
                mb_r <= {1'b0, ax};
                ay_r <= ay;
                st_r <= U_E1;
              end
              default: begin
                res_r  <= '0;
              end
            endcase
          end
        end
        U_MUL: st_r <= U_MFIN;
        U_MFIN: begin
          res_r  <= mul_res;
          st_r   <= U_IDLE;
        end
        U_DIV: begin
          rem_r <= dge ? dstep - {1'b0, dsr_r} : dstep;
          quo_r <= {quo_r[DW-2:0], dge};
          dvd_r <= dvd_r << 1;
          cnt_r <= cnt_r - CW'(1);
          if (cnt_r == CW'(1)) st_r <= U_DFIN;
        end
        U_DFIN: begin
          res_r  <= div_res;
          st_r   <= U_IDLE;
        end
        U_E1: begin
          ma_r <= {1'b0, ay_r};
          mb_r <= {1'b0, ay_r};
          st_r <= U_E2;
        end
        U_E2: begin
          sq_r <= p_r[63:0];
          st_r <= U_E3;
        end
        U_E3: begin
          if (e_sum[64]) begin
            res_r  <= 32'hFFFF_FFFF;
            st_r   <= U_IDLE;
          end else begin
            rad_r  <= e_sum[63:0];
            srem_r <= '0;
            root_r <= '0;
            cnt_r  <= CW'(32);
            st_r   <= U_SQRT;
          end
        end
        U_SQRT: begin
          srem_r <= sge ? sstep - strial : sstep;
          root_r <= {root_r[30:0], sge};
          rad_r  <= rad_r << 2;
          cnt_r  <= cnt_r - CW'(1);
          if (cnt_r == CW'(1)) st_r <= U_SFIN;
        end
        U_SFIN: begin
          res_r  <= root_r;
          st_r   <= U_IDLE;
        end
        default: st_r <= U_IDLE;
      endcase
    end
  end

  assign rsp.done  = done_r;
  assign rsp.fault = fault_r;
  assign rsp.res   = res_r;

endmodule

// ===== src/point_reprojection_error.sv =====
// Top level: pinhole reprojection with lens distortion and error statistics.
// Depends on pre_pkg and pre_alu.
// A load word is written in idle and leaves the block ready. A point word runs the microcode
// on the shared unit step by step: add and multiply steps, masked steps only fetched, the 5 or 6
// bit-serial divides and the distance root, plus the mean divide on a last point.
// Zero divisors shorten a divide.
// One word at a time; the next word is taken once the result sits in the output register.
// Reset (sync, active low) clears mode, error sum, point count and handshakes;
// the coefficient store is not cleared and must be loaded before the first point.
module point_reprojection_error #(
  parameter int MAX_POINTS = 4096,
  parameter int FRAC_BITS  = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  pre_pkg::pre_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output pre_pkg::pre_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_data
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FETCH = 3'd1;
  localparam logic [2:0] S_ISSUE = 3'd2;
  localparam logic [2:0] S_WAIT  = 3'd3;
  localparam logic [2:0] S_ACC   = 3'd4;
  localparam logic [2:0] S_MEAN  = 3'd5;
  localparam logic [2:0] S_MWAIT = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  localparam logic [31:0] FX_ONE  = 32'd1 << FRAC_BITS;
  localparam logic [15:0] MAX_CNT = 16'(MAX_POINTS);
  localparam logic [pre_pkg::PC_W-1:0] PC_LAST = pre_pkg::PC_W'(pre_pkg::UC_LEN - 1);

  logic [2:0]                  state_r;
  logic [pre_pkg::PC_W-1:0]    pc_r;
  logic [1:0]                  mode_r;
  logic signed [31:0]          mx_r, my_r, ix_r, iy_r, u_r, v_r;
  logic                        last_r, fault_r;
  logic [31:0]                 perr_r, mean_r;
  logic [pre_pkg::SUM_W-1:0]   sum_r;
  logic [pre_pkg::CNT_W-1:0]   cnt_r;
  pre_pkg::pre_out_t           out_r;
  logic                        out_valid_r;
  logic                        out_load;

  // operand file: coefficients plus scratch words
  logic [31:0] mem [pre_pkg::MEM_DEPTH];
  logic [31:0] rda_r, rdb_r;
  logic [5:0]  sela_r, selb_r;

  pre_pkg::pre_uop_t uop;
  logic              run;
  logic signed [31:0] opa, opb;
  logic              mem_we;
  logic [5:0]        mem_wa;
  logic [31:0]       mem_wd;
  pre_pkg::pre_req_t alu_req;
  pre_pkg::pre_rsp_t alu_rsp;

  assign uop       = pre_pkg::UCODE[pc_r];
  assign run       = uop.mask[mode_r];
  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_load  = (state_r == S_OUT) && (!out_valid_r || out_ready);

  // constants and the latched point bypass the file
  always_comb begin
    case (sela_r)
      pre_pkg::A_ONE:  opa = FX_ONE;
      pre_pkg::A_ZERO: opa = '0;
      pre_pkg::A_MX:   opa = mx_r;
      pre_pkg::A_MY:   opa = my_r;
      default:         opa = rda_r;
    endcase
    case (selb_r)
      pre_pkg::A_ONE:  opb = FX_ONE;
      pre_pkg::A_ZERO: opb = '0;
      pre_pkg::A_MX:   opb = mx_r;
      pre_pkg::A_MY:   opb = my_r;
      default:         opb = rdb_r;
    endcase
  end

  // loads write in idle, results other than the distance write back when the unit finishes
  always_comb begin
    if (state_r == S_IDLE) begin
      mem_we = in_valid && (in_data.opcode == pre_pkg::IN_LOAD) &&
               (in_data.coef_index < 5'(pre_pkg::STORE_WORDS));
      mem_wa = {1'b0, in_data.coef_index};
      mem_wd = in_data.coef_value;
    end else begin
      mem_we = (state_r == S_WAIT) && alu_rsp.done && (uop.op != pre_pkg::OP_ERR);
      mem_wa = uop.dst;
      mem_wd = alu_rsp.res;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (state_r == S_FETCH) begin
      rda_r <= mem[uop.sa];
      rdb_r <= mem[uop.sb];
    end
  end

  always_comb begin
    alu_req.start = (state_r == S_ISSUE) || (state_r == S_MEAN);
    alu_req.op    = (state_r == S_MEAN) ? pre_pkg::OP_MEAN : uop.op;
    alu_req.a     = opa;
    alu_req.b     = opb;
    alu_req.img_x = ix_r;
    alu_req.img_y = iy_r;
    alu_req.sum   = sum_r;
    alu_req.cnt   = cnt_r;
  end

  pre_alu #(.FRAC_BITS(FRAC_BITS)) u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (alu_req),
    .rsp   (alu_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pc_r        <= '0;
      mode_r      <= '0;
      sum_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) mode_r <= cfg_data;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_valid && in_data.opcode == pre_pkg::IN_POINT) begin
            mx_r    <= in_data.model_x;
            my_r    <= in_data.model_y;
            ix_r    <= in_data.image_x;
            iy_r    <= in_data.image_y;
            last_r  <= in_data.last_point;
            fault_r <= 1'b0;
            pc_r    <= '0;
            state_r <= S_FETCH;
          end
        end
        S_FETCH: begin
          // steps masked off for this mode advance in fetch and never reach the unit
          if (run) begin
            sela_r  <= uop.sa;
            selb_r  <= uop.sb;
            state_r <= S_ISSUE;
          end else if (pc_r == PC_LAST) begin
            state_r <= S_ACC;
          end else begin
            pc_r <= pc_r + pre_pkg::PC_W'(1);
          end
        end
        S_ISSUE: begin
          if (uop.op == pre_pkg::OP_ERR) begin
            u_r <= opa;
            v_r <= opb;
          end
          state_r <= S_WAIT;
        end
        S_WAIT: begin
          if (alu_rsp.done) begin
            fault_r <= fault_r | alu_rsp.fault;
            if (uop.op == pre_pkg::OP_ERR) perr_r <= alu_rsp.res;
            if (pc_r == PC_LAST) begin
              state_r <= S_ACC;
            end else begin
              pc_r    <= pc_r + pre_pkg::PC_W'(1);
              state_r <= S_FETCH;
            end
          end
        end
        S_ACC: begin
          // points past the set limit are reported but not counted
          if (cnt_r < MAX_CNT) begin
            sum_r <= sum_r + {16'b0, perr_r};
            cnt_r <= cnt_r + 16'd1;
          end
          mean_r  <= '0;
          state_r <= last_r ? S_MEAN : S_OUT;
        end
        S_MEAN: state_r <= S_MWAIT;
        S_MWAIT: begin
          if (alu_rsp.done) begin
            mean_r  <= alu_rsp.res;
            sum_r   <= '0;
            cnt_r   <= '0;
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            out_r.proj_u      <= u_r;
            out_r.proj_v      <= v_r;
            out_r.point_error <= perr_r;
            out_r.mean_error  <= mean_r;
            out_r.status      <= fault_r;
            out_r.is_last     <= last_r;
            state_r           <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    alu_rsp.done |-> (state_r == S_WAIT || state_r == S_MWAIT))
    else $error("unit finished with no operation pending");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= MAX_CNT)
    else $error("point count past limit");

  a_busy_after_point: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_data.opcode == pre_pkg::IN_POINT) |=> !in_ready)
    else $error("took a word while a point is in flight");

  a_mean_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.is_last) |-> (out_data.mean_error == '0))
    else $error("mean reported on a non-final point");

endmodule

// ===== tb/pre_checker.sv =====
// Scoreboard for point_reprojection_error: watches the three channels and predicts each result.
// Depends on pre_pkg; instantiated by tb_point_reprojection_error.
`timescale 1ns / 100ps
module pre_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  pre_pkg::pre_in_t  in_data,
  input  logic              out_valid,
  input  logic              out_ready,
  input  pre_pkg::pre_out_t out_data,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [1:0]        cfg_data,
  output int                errors,
  output int                pending
);

  localparam longint FX1  = 64'sd65536;
  localparam longint SMAX = 64'sd2147483647;
  localparam longint SMIN = -64'sd2147483648;
  localparam int     MAXP = 4096;

  logic signed [31:0] coef_mem [pre_pkg::STORE_WORDS];
  longint unsigned    err_acc;
  int unsigned        pt_cnt;
  logic [1:0]         dist_mode;
  bit                 div_zero;
  pre_pkg::pre_out_t  result_q [$];

  function automatic longint sat(longint v);
    if (v > SMAX) return SMAX;
    if (v < SMIN) return SMIN;
    return v;
  endfunction

  function automatic longint fadd(longint a, longint b);
    return sat(a + b);
  endfunction

  function automatic longint fmul(longint a, longint b);
    longint p;
    p = a * b;
    if (p >= 0) return sat(p >>> 16);
    return sat(-(((-p) + FX1 - 1) >>> 16));
  endfunction

  function automatic longint fdiv(longint n, longint d);
    if (d == 0) begin
      div_zero = 1'b1;
      return (n >= 0) ? SMAX : SMIN;
    end
    return sat((n * FX1) / d);
  endfunction

  function automatic longint cf(int i);
    return longint'(coef_mem[i]);
  endfunction

  function automatic longint unsigned isqrt(longint unsigned s);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b = b >> 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s = s - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Full projection of one point word against the current store and mode
  function automatic pre_pkg::pre_out_t project_point(pre_pkg::pre_in_t w);
    pre_pkg::pre_out_t o;
    longint mx, my, p[3], x, y, z, q[3], u, v, r2, xx, dr, dt, r3, r22, r33, ku, kd, dx, dy;
    longint unsigned ax, ay, sq, sm, perr, mean;
    mean = 0;
    div_zero = 1'b0;
    mx = longint'(w.model_x);
    my = longint'(w.model_y);
    for (int r = 0; r < 3; r++)
      p[r] = fadd(fadd(fmul(cf(3*r), mx), fmul(cf(3*r+1), my)), cf(3*r+2));
    x = fdiv(p[0], p[2]);
    y = fdiv(p[1], p[2]);
    z = fdiv(p[2], p[2]);
    if (dist_mode != 0) begin
      xx = fmul(x, x);
      r2 = fadd(fadd(xx, fmul(y, y)), FX1);
      if (dist_mode == 3) begin
        r3  = fadd(fadd(fmul(xx, x), fmul(fmul(y, y), y)), FX1);
        r22 = fmul(r2, r2);
        r33 = fmul(r3, r3);
        ku = fadd(fadd(fadd(FX1, fmul(cf(18), r2)), fmul(cf(19), r22)), fmul(cf(20), r33));
        kd = fadd(fadd(fadd(FX1, fmul(cf(21), r2)), fmul(cf(22), r22)), fmul(cf(23), r33));
        // zero rational denominator: no distortion gain, no status
        dr = (kd != 0) ? fdiv(ku, kd) : 0;
      end else begin
        dr = fadd(fadd(FX1, fmul(cf(18), r2)), fmul(cf(19), fmul(r2, r2)));
      end
      if (dist_mode == 1) dt = 0;
      else dt = fadd(fmul(fmul(sat(2 * cf(20)), x), y), fmul(cf(21), fadd(r2, sat(2 * xx))));
      x = fadd(fmul(x, dr), dt);
      y = fadd(fmul(y, dr), dt);
    end
    for (int r = 0; r < 3; r++)
      q[r] = fadd(fadd(fmul(cf(9+3*r), x), fmul(cf(10+3*r), y)), fmul(cf(11+3*r), z));
    u = fdiv(q[0], q[2]);
    v = fdiv(q[1], q[2]);
    dx = longint'(w.image_x) - u;
    dy = longint'(w.image_y) - v;
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    sq = ax * ax;
    sm = sq + ay * ay;
    perr = (sm < sq) ? 64'hFFFF_FFFF : isqrt(sm);
    if (perr > 64'hFFFF_FFFF) perr = 64'hFFFF_FFFF;
    if (pt_cnt < MAXP) begin
      err_acc += perr;
      pt_cnt++;
    end
    if (w.last_point) begin
      if (pt_cnt != 0) mean = err_acc / pt_cnt;
      if (mean > 64'hFFFF_FFFF) mean = 64'hFFFF_FFFF;
      err_acc = 0;
      pt_cnt  = 0;
    end
    o.proj_u      = u[31:0];
    o.proj_v      = v[31:0];
    o.point_error = perr[31:0];
    o.mean_error  = mean[31:0];
    o.status      = div_zero;
    o.is_last     = w.last_point;
    return o;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch @%0t: %s got %h want %h", $realtime, what, got, want);
    errors++;
  endtask

  assign pending = result_q.size();

  always @(posedge clk) begin
    pre_pkg::pre_out_t want;
    if (!rst_n) begin
      err_acc   = 0;
      pt_cnt    = 0;
      dist_mode = 2'd0;
      errors    = 0;
      result_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) dist_mode = cfg_data;
      if (in_valid && in_ready) begin
        if (in_data.opcode == pre_pkg::IN_LOAD) begin
          if (in_data.coef_index < pre_pkg::STORE_WORDS)
            coef_mem[in_data.coef_index] = in_data.coef_value;
        end else begin
          result_q = {result_q, project_point(in_data)};
        end
      end
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          report("unexpected word", longint'(out_data.point_error), 0);
        end else begin
          want = result_q.pop_front();
          if (out_data.proj_u !== want.proj_u) report("proj_u", out_data.proj_u, want.proj_u);
          if (out_data.proj_v !== want.proj_v) report("proj_v", out_data.proj_v, want.proj_v);
          if (out_data.point_error !== want.point_error)
            report("point_error", out_data.point_error, want.point_error);
          if (out_data.mean_error !== want.mean_error)
            report("mean_error", out_data.mean_error, want.mean_error);
          if (out_data.status !== want.status) report("status", out_data.status, want.status);
          if (out_data.is_last !== want.is_last) report("is_last", out_data.is_last, want.is_last);
        end
      end
    end
  end

endmodule

// ===== tb/tb_point_reprojection_error.sv =====
// Stimulus and verdict for point_reprojection_error; pre_checker does the prediction.
// Depends on pre_pkg, the block under test and tb/pre_checker.sv.
`timescale 1ns / 100ps
module tb_point_reprojection_error;

  localparam int FX1 = 65536;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  pre_pkg::pre_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  pre_pkg::pre_out_t out_data;
  logic     cfg_valid;
  logic     cfg_ready;
  logic [1:0] cfg_data;
  int       errors;
  int       pending;

  // sender burst bookkeeping
  int burst_left;
  int items_sent;

  point_reprojection_error dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  pre_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop well past the slowest legal run, stalls included
  initial begin
    #50ms;
    $display("DONE: errors detected");
    $finish;
  end

  // Receiver: regimes of different stall shapes, including plain always-ready stretches.
  initial begin
    int regime, left, run;
    out_ready = 1'b0;
    regime = 0;
    left = 0;
    run = 0;
    forever begin
      @(posedge clk);
      if (left == 0) begin
        regime = $urandom_range(0, 3);
        left = $urandom_range(64, 1024);
      end
      left--;
      case (regime)
        0: out_ready <= 1'b1;
        1: out_ready <= $urandom_range(0, 1);
        2: out_ready <= ($urandom_range(0, 7) != 0);
        default: begin
          // long stalls with short open windows
          if (run == 0) run = $urandom_range(1, 40);
          run--;
          out_ready <= (run < 3);
        end
      endcase
    end
  end

  // Small signed Q16.16 value in +-lim (lim in 1/256 units)
  function automatic int small_fx(int lim);
    return ($urandom_range(0, 2 * lim) - lim) * 256;
  endfunction

  // Plausible camera: near-identity pose at depth ~5, 500 px focal length, mild distortion
  function automatic int sane_word(int idx);
    case (idx)
      0, 4:   return FX1 + small_fx(25);
      2, 5:   return small_fx(256);
      8:      return 5 * FX1 + small_fx(512);
      9, 13:  return 500 * FX1 + small_fx(2560);
      11:     return 320 * FX1 + small_fx(1280);
      14:     return 240 * FX1 + small_fx(1280);
      17:     return FX1;
      10, 12, 15, 16: return small_fx(2);
      default: begin
        if (idx >= 18) return small_fx(25);
        return small_fx(25);
      end
    endcase
  endfunction

  // Push one word; sender keeps random bursts and gaps between them.
  // Called at a clock edge; returns at the edge that accepted the word.
  task automatic send_word(pre_pkg::pre_in_t w);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 700) : $urandom_range(0, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    // valid is left high; the next call lowers it or replaces the payload
  endtask

  task automatic load_word(int idx, int val);
    pre_pkg::pre_in_t w;
    w.opcode     = pre_pkg::IN_LOAD;
    w.coef_index = idx[4:0];
    w.coef_value = val;
    w.model_x    = $urandom;
    w.model_y    = $urandom;
    w.image_x    = $urandom;
    w.image_y    = $urandom;
    w.last_point = $urandom_range(0, 1);
    send_word(w);
  endtask

  task automatic point_word(int mx, int my, int ix, int iy, logic last);
    pre_pkg::pre_in_t w;
    w.opcode     = pre_pkg::IN_POINT;
    w.coef_index = $urandom;
    w.coef_value = $urandom;
    w.model_x    = mx;
    w.model_y    = my;
    w.image_x    = ix;
    w.image_y    = iy;
    w.last_point = last;
    send_word(w);
  endtask

  task automatic load_camera();
    for (int i = 0; i < pre_pkg::STORE_WORDS; i++) load_word(i, sane_word(i));
  endtask

  // Mode change only with the block drained; loads leave nothing in the queue, so pad a bit
  task automatic set_mode(logic [1:0] m);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int mx, my, ix, iy, n;
    logic [1:0] mode;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    cfg_valid  = 1'b0;
    cfg_data   = 2'd0;
    burst_left = 0;
    items_sent = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // --- directed part ---
    set_mode(2'd0);
    load_camera();
    point_word(0, 0, 320 * FX1, 240 * FX1, 1'b0);
    point_word(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 1'b0);
    point_word(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
    load_word(24, $urandom);   // out-of-range indices are dropped
    load_word(31, $urandom);
    // zero depth: third pose row cleared
    for (int i = 6; i < 9; i++) load_word(i, 0);
    point_word(FX1, FX1, 300 * FX1, 200 * FX1, 1'b0);
    for (int i = 6; i < 9; i++) load_word(i, sane_word(i));
    // zero final divisor: third intrinsic row cleared
    for (int i = 15; i < 18; i++) load_word(i, 0);
    point_word(-FX1, FX1, 300 * FX1, 200 * FX1, 1'b1);
    for (int i = 15; i < 18; i++) load_word(i, sane_word(i));
    // rational denominator zero: x = y = 0 gives r2 = 1 and kd = 1 - 1
    set_mode(2'd3);
    for (int i = 0; i < 6; i++) load_word(i, 0);
    for (int i = 18; i < 24; i++) load_word(i, (i == 21) ? -FX1 : 0);
    point_word(FX1, -FX1, 320 * FX1, 240 * FX1, 1'b1);
    set_mode(2'd2);
    load_camera();
    point_word(FX1 / 2, -FX1 / 2, 330 * FX1, 250 * FX1, 1'b1);

    // --- random part: phases over all modes, extremes included ---
    while (items_sent < 1450) begin
      mode = $urandom_range(0, 3);
      set_mode(mode);
      load_camera();
      n = $urandom_range(60, 120);
      for (int k = 0; k < n; k++) begin
        if ($urandom_range(0, 99) < 15) begin
          // stray load: mostly plausible, sometimes any bits, any index
          if ($urandom_range(0, 2) == 0) load_word($urandom_range(0, 31), $urandom);
          else begin
            ix = $urandom_range(0, 23);
            load_word(ix, sane_word(ix));
          end
        end else begin
          if ($urandom_range(0, 4) == 0) begin
            mx = $urandom;
            my = $urandom;
          end else begin
            mx = small_fx(512);
            my = small_fx(512);
          end
          if ($urandom_range(0, 4) == 0) begin
            ix = $urandom;
            iy = $urandom;
          end else begin
            ix = 320 * FX1 + small_fx(40000);
            iy = 240 * FX1 + small_fx(40000);
          end
          point_word(mx, my, ix, iy, ($urandom_range(0, 7) == 0));
        end
      end
      // close the set so the mean is checked
      point_word(small_fx(256), small_fx(256), 320 * FX1, 240 * FX1, 1'b1);
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
